// ----- rtl/core/mwo_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the oscillator.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package mwo_pkg;

  // Datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  // Fixed field widths
  localparam int FREQ_W  = 24;
  localparam int PPH_W   = 28;
  localparam int SLOPE_W = 16;
  localparam int WSEL_W  = 2;

  // Step = (freq * phase_per_hz) >> STEP_SHIFT
  localparam int PROD_W     = FREQ_W + PPH_W;
  localparam int STEP_SHIFT = 48 - PHASE_BITS;

  // Sine table: N + 1 entries, magnitudes of SAMPLE_BITS-1 bits
  localparam int TAB_N   = 1 << SINE_TABLE_BITS;
  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int ADDR_W  = SINE_TABLE_BITS + 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned AMP_MAX     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Triangle: p * slope in Q40, value = (m * 4) >> (41 - SAMPLE_BITS)
  localparam int TRI_P_W   = 32;
  localparam int TRI_A_W   = TRI_P_W + SLOPE_W;
  localparam int TRI_B_W   = TRI_P_W + 1 + SLOPE_W;
  localparam int TRI_SHIFT = 39 - SAMPLE_BITS;
  localparam int TRI_T_W   = TRI_B_W - TRI_SHIFT;

  // Step queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [FREQ_W-1:0] FIXED_FREQ_RST = 24'd112640;
  localparam logic [PPH_W-1:0]  PPH_RST        = 28'd22906492;
  localparam logic [SLOPE_W-1:0] SLOPE_RST     = 16'd256;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WAVE_SEL  = 3'd0,
    REG_PS_ENABLE = 3'd1,
    REG_FIXED_FREQ = 3'd2,
    REG_PHASE_PER_HZ = 3'd3,
    REG_UP_SLOPE  = 3'd4,
    REG_DOWN_SLOPE = 3'd5
  } reg_idx_t;

  typedef enum logic [WSEL_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_PHASOR   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_sel_t;

  typedef logic [PHASE_BITS-1:0] step_t;

  // Waveform controls seen by the back end
  typedef struct packed {
    logic [WSEL_W-1:0]  wave_sel;
    logic [SLOPE_W-1:0] up_slope;
    logic [SLOPE_W-1:0] down_slope;
  } wave_cfg_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:TAB_N];

  // Shift-and-subtract long division; only evaluated while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One table entry: Q30 Taylor series of sin(pi/2 * k / N), 11 terms
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] dvs;
    x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    term = x;
    sum  = x;
    for (int n = 1; n <= 10; n++) begin
      dvs  = 64'((2 * n) * (2 * n + 1));
      term = (term * x) >> 30;
      term = udiv64((term * x) >> 30, dvs);
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    v = (sum * AMP_MAX + (64'd1 << 29)) >> 30;
    if (v > AMP_MAX) v = AMP_MAX;
    return v[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k <= TAB_N; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/core/mwo_front.sv -----
// Front end: takes one sample tick, picks its frequency and forms the phase step.
// Depends on mwo_pkg.
`timescale 1ns / 1ps

module mwo_front import mwo_pkg::*; (
  input  logic                 push,
  input  logic [FREQ_W-1:0]    in_freq_hz,
  input  logic                 q_full,
  input  logic                 ps_enable,
  input  logic [FREQ_W-1:0]    fixed_freq,
  input  logic [PPH_W-1:0]     phase_per_hz,
  output logic                 full,
  output logic                 q_push,
  output step_t                q_step
);

  logic [FREQ_W-1:0] freq_sel;
  logic [PROD_W-1:0] prod;

  // Accept when the step queue has room
  assign full   = q_full;
  assign q_push = push & ~q_full;

  // Frequency select and step multiply
  assign freq_sel = ps_enable ? in_freq_hz : fixed_freq;
  assign prod     = PROD_W'(freq_sel) * PROD_W'(phase_per_hz);
  assign q_step   = PHASE_BITS'(prod >> STEP_SHIFT);

endmodule

// ----- rtl/core/mwo_queue.sv -----
// Short FIFO of phase steps between the front and back ends.
// Depends on mwo_pkg.
`timescale 1ns / 1ps

module mwo_queue import mwo_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  step_t wr_data,
  input  logic  rd_en,
  output step_t rd_data,
  output logic  q_full,
  output logic  q_empty
);

  step_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/mwo_back.sv -----
// Back end: phase accumulator, waveform pipeline and the result register.
// Depends on mwo_pkg (sine table, widths, waveform codes).
`timescale 1ns / 1ps

module mwo_back import mwo_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wave_cfg_t                     wcfg,
  input  logic                          q_empty,
  input  step_t                         q_step,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  logic                      adv;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [PHASE_BITS-1:0]     phase_nxt;

  // Stage 0 decode of the current phase
  logic [1:0]                quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_W-1:0]         rom_addr;
  logic [MAG_W-1:0]          phasor;
  logic [TRI_P_W-1:0]        tri_p;
  logic [TRI_P_W:0]          tri_q;

  // Stage 1 registers
  logic                      s1_valid_r;
  logic [MAG_W-1:0]          rom_q_r;
  logic                      s1_neg_r;
  logic [MAG_W-1:0]          s1_phasor_r;
  logic [TRI_A_W-1:0]        s1_a_r;
  logic [TRI_B_W-1:0]        s1_b_r;

  // Stage 2 / result register
  logic                      s2_valid_r;
  logic [SAMPLE_BITS-1:0]    sample_r;
  logic [SAMPLE_BITS-1:0]    sample_nxt;

  logic [TRI_B_W-1:0]        tri_m;
  logic [TRI_T_W-1:0]        tri_t;
  logic [SAMPLE_BITS-1:0]    tri_val;
  logic [SAMPLE_BITS-1:0]    sine_val;

  // Pipeline moves when the result register is free or being drained
  assign adv   = ~s2_valid_r | pop;
  assign q_pop = adv & ~q_empty;
  assign empty = ~s2_valid_r;
  assign out_sample = sample_r;

  // Phase accumulator: this transaction uses phase_r, then advances it
  assign phase_nxt = phase_r + q_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
    end
  end

  // Phase decode for each waveform
  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign idx      = phase_r[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? ADDR_W'(TAB_N - int'(idx)) : ADDR_W'(idx);
  assign phasor   = MAG_W'({phase_r, {MAG_W{1'b0}}} >> PHASE_BITS);
  assign tri_p    = TRI_P_W'({phase_r, {TRI_P_W{1'b0}}} >> PHASE_BITS);
  assign tri_q    = {1'b1, {TRI_P_W{1'b0}}} - {1'b0, tri_p};

  // Stage 1: table read and triangle products
  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r     <= SINE_ROM[rom_addr];
      s1_neg_r    <= quad[1];
      s1_phasor_r <= phasor;
      s1_a_r      <= TRI_A_W'(tri_p) * TRI_A_W'(wcfg.up_slope);
      s1_b_r      <= TRI_B_W'(tri_q) * TRI_B_W'(wcfg.down_slope);
    end
  end

  // Triangle: min of both slopes, scale, offset by -1, saturate high
  assign tri_m   = (TRI_B_W'(s1_a_r) < s1_b_r) ? TRI_B_W'(s1_a_r) : s1_b_r;
  assign tri_t   = tri_m[TRI_B_W-1:TRI_SHIFT];
  assign tri_val = (|tri_t[TRI_T_W-1:SAMPLE_BITS]) ?
                   {1'b0, {(SAMPLE_BITS-1){1'b1}}} :
                   {~tri_t[SAMPLE_BITS-1], tri_t[SAMPLE_BITS-2:0]};

  // Sine: negate in the lower half cycle
  assign sine_val = s1_neg_r ? (SAMPLE_BITS'(0) - {1'b0, rom_q_r}) : {1'b0, rom_q_r};

  always_comb begin
    case (wcfg.wave_sel)
      WAVE_SINE:     sample_nxt = sine_val;
      WAVE_PHASOR:   sample_nxt = {1'b0, s1_phasor_r};
      WAVE_TRIANGLE: sample_nxt = tri_val;
      default:       sample_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r <= sample_nxt;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
      s2_valid_r <= s1_valid_r;
    end
  end

endmodule

// ----- rtl/core/multi_waveform_oscillator.sv -----
// Multi-waveform DDS oscillator: top level with configuration registers.
// Depends on mwo_pkg, mwo_front, mwo_queue and mwo_back.
//
// Usage:
//   Input queue: push/full with in_freq_hz. Each transaction is one sample tick.
//   Result queue: empty/pop with out_sample, the waveform at the phase held
//   before that tick; the phase then adds (freq * phase_per_hz) >> 16.
//   Config: APB-style, registers at byte address 4*i (waveform_select,
//   per_sample_freq_enable, fixed_freq, phase_per_hz, up_slope, down_slope).
//   pready is always high; writes are expected only while the block is idle.
// Timing:
//   One transaction per cycle sustained as long as pop is held high.
//   An accepted tick passes the step queue, then the table read/multiply
//   stage, then the result register before it shows on the ports.
//   The phase accumulator adds one step per cycle while ticks are popped.
// Reset (rst_n low, synchronous): phase cleared to zero, registers take their
//   defaults, both queues empty.
// Stall: while pop is low and a result waits, the result register holds;
//   the back end stops and the 4-entry step queue fills until full rises.
`timescale 1ns / 1ps

module multi_waveform_oscillator import mwo_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // input queue
  input  logic                          push,
  output logic                          full,
  input  logic [FREQ_W-1:0]             in_freq_hz,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready
);

  logic [WSEL_W-1:0]  wave_sel_r;
  logic               ps_enable_r;
  logic [FREQ_W-1:0]  fixed_freq_r;
  logic [PPH_W-1:0]   phase_per_hz_r;
  logic [SLOPE_W-1:0] up_slope_r;
  logic [SLOPE_W-1:0] down_slope_r;

  logic               wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  wave_cfg_t          wcfg;

  logic               q_push;
  step_t              q_wr_step;
  logic               q_pop;
  step_t              q_rd_step;
  logic               q_full;
  logic               q_empty;

  // Register file
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r     <= WAVE_SINE;
      ps_enable_r    <= 1'b0;
      fixed_freq_r   <= FIXED_FREQ_RST;
      phase_per_hz_r <= PPH_RST;
      up_slope_r     <= SLOPE_RST;
      down_slope_r   <= SLOPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVE_SEL:     wave_sel_r     <= pwdata[WSEL_W-1:0];
        REG_PS_ENABLE:    ps_enable_r    <= pwdata[0];
        REG_FIXED_FREQ:   fixed_freq_r   <= pwdata[FREQ_W-1:0];
        REG_PHASE_PER_HZ: phase_per_hz_r <= pwdata[PPH_W-1:0];
        REG_UP_SLOPE:     up_slope_r     <= pwdata[SLOPE_W-1:0];
        REG_DOWN_SLOPE:   down_slope_r   <= pwdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_WAVE_SEL:     prdata = CFG_DATA_W'(wave_sel_r);
      REG_PS_ENABLE:    prdata = CFG_DATA_W'(ps_enable_r);
      REG_FIXED_FREQ:   prdata = CFG_DATA_W'(fixed_freq_r);
      REG_PHASE_PER_HZ: prdata = CFG_DATA_W'(phase_per_hz_r);
      REG_UP_SLOPE:     prdata = CFG_DATA_W'(up_slope_r);
      REG_DOWN_SLOPE:   prdata = CFG_DATA_W'(down_slope_r);
      default:          prdata = '0;
    endcase
  end

  assign wcfg.wave_sel   = wave_sel_r;
  assign wcfg.up_slope   = up_slope_r;
  assign wcfg.down_slope = down_slope_r;

  mwo_front u_front (
    .push         (push),
    .in_freq_hz   (in_freq_hz),
    .q_full       (q_full),
    .ps_enable    (ps_enable_r),
    .fixed_freq   (fixed_freq_r),
    .phase_per_hz (phase_per_hz_r),
    .full         (full),
    .q_push       (q_push),
    .q_step       (q_wr_step)
  );

  mwo_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_step),
    .rd_en   (q_pop),
    .rd_data (q_rd_step),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mwo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wcfg       (wcfg),
    .q_empty    (q_empty),
    .q_step     (q_rd_step),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_sample (out_sample)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for multi_waveform_oscillator: directed table, then random ticks
// and register settings, checked against an in-bench predictor or a row's typed value.
// Depends on mwo_pkg and the RTL in rtl/core only.
`timescale 1ns / 1ps

module testbench;
  import mwo_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;      // pipeline drain plus margin
  localparam int HOLD_CYCLES  = 64;     // long receiver stall, well past queue depth
  localparam int SEG_ITEMS    = 122;
  localparam int DIR_ROWS     = 25;
  localparam int N_REGS       = 6;
  localparam int FREQ_SHIFT   = 48 - PHASE_BITS;

  localparam logic [WSEL_W-1:0] WAVE_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;

  // DUT ports
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [FREQ_W-1:0]             in_freq_hz = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]         paddr = '0;
  logic [CFG_DATA_W-1:0]         pwdata = '0;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;

  // Typed expectation travels with the transaction
  logic                          exp_given = 1'b0;
  logic signed [SAMPLE_BITS-1:0] exp_typed = '0;

  // Predictor copy of registers and phase
  logic [WSEL_W-1:0]     cfg_wave  = WAVE_SINE;
  logic                  cfg_ps    = 1'b0;
  logic [FREQ_W-1:0]     cfg_fixed = FIXED_FREQ_RST;
  logic [PPH_W-1:0]      cfg_pph   = PPH_RST;
  logic [SLOPE_W-1:0]    cfg_up    = SLOPE_RST;
  logic [SLOPE_W-1:0]    cfg_down  = SLOPE_RST;
  logic [PHASE_BITS-1:0] model_phase = '0;

  logic [MAG_W-1:0] quarter_tab [0:TAB_N];
  logic signed [SAMPLE_BITS-1:0] pending_samples [$];

  int          err_count     = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 66;
  int unsigned stall_asks    = 0;

  typedef struct packed {
    logic                          set_cfg;
    logic [WSEL_W-1:0]             wave;
    logic                          ps_en;
    logic [FREQ_W-1:0]             fixed;
    logic [PPH_W-1:0]              pph;
    logic [SLOPE_W-1:0]            up;
    logic [SLOPE_W-1:0]            down;
    logic [FREQ_W-1:0]             freq;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] want;
  } dir_row_t;

  // Directed rows: zero phase after reset, step extremes, zero step, slope extremes,
  // unused waveform code, quadrant walk of the sine, saturating triangle
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000000, 1'b1, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'hFFFFFF, 1'b0, '0},
    '{1'b1, WAVE_PHASOR, 1'b1, '0, 28'hFFFFFFF, 16'h100, 16'h100, 24'hFFFFFF, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000001, 1'b0, '0},
    '{1'b1, WAVE_TRIANGLE, 1'b1, '0, 28'h1, 16'hFFFF, 16'hFFFF, 24'h800000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h7FFFFF, 1'b0, '0},
    '{1'b1, WAVE_TRIANGLE, 1'b0, 24'hFFFFFF, 28'hFFFFFFF, '0, 16'hFFFF, '0, 1'b1, SAMPLE_MIN},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000000, 1'b1, SAMPLE_MIN},
    '{1'b1, WAVE_TRIANGLE, 1'b0, 24'hFFFFFF, 28'hFFFFFFF, 16'hFFFF, '0, '0, 1'b1, SAMPLE_MIN},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000000, 1'b1, SAMPLE_MIN},
    '{1'b1, WAVE_UNUSED, 1'b0, '0, 28'h1000000, 16'h100, 16'h100, 24'hFFFFFF, 1'b1, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h000000, 1'b1, '0},
    '{1'b1, WAVE_UNUSED, 1'b1, '0, 28'hFFFFFFF, 16'h100, 16'h100, 24'hFFFFFF, 1'b1, '0},
    '{1'b1, WAVE_SINE, 1'b1, '0, '0, 16'h100, 16'h100, 24'hFFFFFF, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h123456, 1'b0, '0},
    '{1'b1, WAVE_SINE, 1'b1, '0, 28'h1000000, 16'h100, 16'h100, 24'h400000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h400000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h400000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h400000, 1'b0, '0},
    '{1'b1, WAVE_PHASOR, 1'b1, '0, 28'h1000000, 16'h100, 16'h100, 24'h400000, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h400000, 1'b0, '0},
    '{1'b1, WAVE_TRIANGLE, 1'b1, '0, 28'h1000000, 16'h100, 16'h300, 24'h2AAAAA, 1'b0, '0},
    '{1'b0, WAVE_SINE, 1'b0, '0, '0, '0, '0, 24'h555555, 1'b0, '0},
    '{1'b1, WAVE_TRIANGLE, 1'b1, '0, 28'h1000000, 16'hFFFF, 16'hFFFF, 24'h200000, 1'b0, '0}
  };

  multi_waveform_oscillator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_freq_hz (in_freq_hz),
    .empty      (empty),
    .pop        (pop),
    .out_sample (out_sample),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Quarter-wave sine magnitudes: Q30 Taylor series, 11 terms, rounded to the amplitude
  initial begin : build_quarter_tab
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      term = x;
      acc  = x;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - term : acc + term;
      end
      v = (acc * AMP_MAX + (64'd1 << 29)) >> 30;
      if (v > AMP_MAX) v = AMP_MAX;
      quarter_tab[k] = v[MAG_W-1:0];
    end
  end

  // Waveform value at a phase under the current register copy
  function automatic logic signed [SAMPLE_BITS-1:0] osc_sample(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0]    idx;
    logic [1:0]                    quad;
    logic signed [SAMPLE_BITS-1:0] mag;
    logic [63:0]                   rise;
    logic [63:0]                   fall;
    logic [63:0]                   m;
    longint                        r;
    case (cfg_wave)
      WAVE_SINE: begin
        idx  = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
        quad = ph[PHASE_BITS-1 -: 2];
        mag  = {1'b0, quad[0] ? quarter_tab[TAB_N - int'(idx)] : quarter_tab[idx]};
        return quad[1] ? -mag : mag;
      end
      WAVE_PHASOR: return {1'b0, ph[PHASE_BITS-1 -: SAMPLE_BITS-1]};
      WAVE_TRIANGLE: begin
        rise = 64'(ph[PHASE_BITS-1 -: 32]) * 64'(cfg_up);
        fall = ((64'd1 << 32) - 64'(ph[PHASE_BITS-1 -: 32])) * 64'(cfg_down);
        m    = (rise < fall) ? rise : fall;
        r    = longint'((m * 4) >> (41 - SAMPLE_BITS)) + longint'(SAMPLE_MIN);
        if (r > longint'(SAMPLE_MAX)) r = longint'(SAMPLE_MAX);
        if (r < longint'(SAMPLE_MIN)) r = longint'(SAMPLE_MIN);
        return r[SAMPLE_BITS-1:0];
      end
      default: return '0;
    endcase
  endfunction

  // Scoreboard: check popped samples, predict on each accepted tick
  always @(posedge clk) begin : scoreboard
    logic [FREQ_W-1:0]             f_sel;
    logic [63:0]                   prod;
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_samples.size() == 0) begin
          $error("out_sample: no transaction expected, got %0d", out_sample);
          err_count++;
        end else begin
          want = pending_samples.pop_front();
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, got %0d", want, out_sample);
            err_count++;
          end
        end
      end
      if (push && !full) begin
        pending_samples.push_back(exp_given ? exp_typed : osc_sample(model_phase));
        f_sel       = cfg_ps ? in_freq_hz : cfg_fixed;
        prod        = 64'(f_sel) * 64'(cfg_pph);
        model_phase = model_phase + prod[FREQ_SHIFT +: PHASE_BITS];
      end
    end
  end

  // Receiver: random pops, long hold-off on request
  initial begin : sink
    int unsigned hold_left;
    int unsigned stalls_seen;
    hold_left   = 0;
    stalls_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_asks != stalls_seen) begin
        stalls_seen = stall_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // APB write; updates the register copy with the masked value
  task automatic write_reg(input int unsigned idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WAVE_SEL:     cfg_wave  = data[WSEL_W-1:0];
      REG_PS_ENABLE:    cfg_ps    = data[0];
      REG_FIXED_FREQ:   cfg_fixed = data[FREQ_W-1:0];
      REG_PHASE_PER_HZ: cfg_pph   = data[PPH_W-1:0];
      REG_UP_SLOPE:     cfg_up    = data[SLOPE_W-1:0];
      REG_DOWN_SLOPE:   cfg_down  = data[SLOPE_W-1:0];
      default: ;
    endcase
  endtask

  // Read back every register and compare with the copy
  task automatic check_regs();
    reg_idx_t              ri;
    logic [CFG_DATA_W-1:0] want;
    for (int i = 0; i < N_REGS; i++) begin
      ri = reg_idx_t'(i);
      case (ri)
        REG_WAVE_SEL:     want = CFG_DATA_W'(cfg_wave);
        REG_PS_ENABLE:    want = CFG_DATA_W'(cfg_ps);
        REG_FIXED_FREQ:   want = CFG_DATA_W'(cfg_fixed);
        REG_PHASE_PER_HZ: want = CFG_DATA_W'(cfg_pph);
        REG_UP_SLOPE:     want = CFG_DATA_W'(cfg_up);
        default:          want = CFG_DATA_W'(cfg_down);
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CFG_ADDR_W'(i * 4);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== want) begin
        $error("%s: expected %0h, got %0h", ri.name(), want, prdata);
        err_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Full register setting; junk above each field checks masking
  task automatic write_cfg(input logic [WSEL_W-1:0] wave, input logic ps,
                           input logic [FREQ_W-1:0] fixed, input logic [PPH_W-1:0] pph,
                           input logic [SLOPE_W-1:0] up, input logic [SLOPE_W-1:0] down);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    write_reg(REG_WAVE_SEL,     {junk[CFG_DATA_W-1:WSEL_W], wave});
    write_reg(REG_PS_ENABLE,    {junk[CFG_DATA_W-1:1], ps});
    write_reg(REG_FIXED_FREQ,   {junk[CFG_DATA_W-1:FREQ_W], fixed});
    write_reg(REG_PHASE_PER_HZ, {junk[CFG_DATA_W-1:PPH_W], pph});
    write_reg(REG_UP_SLOPE,     {junk[CFG_DATA_W-1:SLOPE_W], up});
    write_reg(REG_DOWN_SLOPE,   {~junk[CFG_DATA_W-1:SLOPE_W], down});
    check_regs();
  endtask

  // Stop offering ticks and let every expected sample drain; the first edge lets the
  // scoreboard record a transaction accepted at the edge just passed
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One tick transaction; push stays high afterwards so back-to-back ticks need no gap
  task automatic push_tick(input logic [FREQ_W-1:0] f, input logic typed,
                           input logic signed [SAMPLE_BITS-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      push       <= 1'b0;
      in_freq_hz <= FREQ_W'($urandom());
      @(posedge clk);
    end
    push       <= 1'b1;
    in_freq_hz <= f;
    exp_given  <= typed;
    exp_typed  <= want;
    do @(posedge clk); while (full);
  endtask

  // Random field value weighted toward zero, full scale and small values
  function automatic logic [31:0] pick_val(input int unsigned w);
    logic [31:0] lim;
    lim = (w >= 32) ? '1 : (32'd1 << w) - 32'd1;
    case ($urandom_range(9))
      0:       return '0;
      1:       return lim;
      2, 3:    return 32'($urandom_range(255));
      default: return $urandom() & lim;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0]       fv;
    logic [31:0]       fx;
    logic [31:0]       pp;
    logic [31:0]       us;
    logic [31:0]       ds;
    logic [31:0]       rv;
    logic [WSEL_W-1:0] wsel;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, then writes to unmapped indexes must change nothing
    check_regs();
    write_reg(N_REGS, $urandom());
    write_reg(N_REGS + 1, $urandom());
    check_regs();

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        wait_idle();
        write_cfg(dir_rows[i].wave, dir_rows[i].ps_en, dir_rows[i].fixed,
                  dir_rows[i].pph, dir_rows[i].up, dir_rows[i].down);
      end
      push_tick(dir_rows[i].freq, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random: three idling profiles, several register settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        wait_idle();
        rv   = $urandom();
        wsel = (rv[3:0] == 4'd0) ? WAVE_UNUSED : WSEL_W'($urandom_range(2));
        fx   = pick_val(FREQ_W);
        pp   = pick_val(PPH_W);
        us   = pick_val(SLOPE_W);
        ds   = pick_val(SLOPE_W);
        write_cfg(wsel, rv[4], fx[FREQ_W-1:0], pp[PPH_W-1:0],
                  us[SLOPE_W-1:0], ds[SLOPE_W-1:0]);
        if (ph == 2 && seg == 1) stall_asks <= stall_asks + 1;
        for (int n = 0; n < SEG_ITEMS; n++) begin
          // sender pause until the pipeline is empty
          if (ph < 2 && seg == 2 && n == SEG_ITEMS / 2) wait_idle();
          fv = pick_val(FREQ_W);
          push_tick(fv[FREQ_W-1:0], 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mwo_pkg.sv
rtl/core/mwo_front.sv
rtl/core/mwo_queue.sv
rtl/core/mwo_back.sv
rtl/core/multi_waveform_oscillator.sv
dv/testbench.sv
